[rtl/dvss_pkg.sv]
// Package with the types, codes and step functions of the dual valve step sequencer.
package dvss_pkg;

    localparam int unsigned NUM_DELAYS = 6;
    localparam int unsigned NUM_SENSORS = 4;

    // Request kinds.
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_COMMAND = 1'b1;

    // Command codes.
    localparam logic [6:0] CMD_START = 7'h55;
    localparam logic [6:0] CMD_STOP  = 7'h33;

    // Channel modes; the unused code behaves as off.
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_TEST = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PRE_DELAY     = 3'd0;
    localparam logic [2:0] CFG_FIRST_DELAY   = 3'd1;
    localparam logic [2:0] CFG_THIRD_DELAY   = 3'd2;
    localparam logic [2:0] CFG_ALL_DELAY     = 3'd3;
    localparam logic [2:0] CFG_RELEASE_DELAY = 3'd4;
    localparam logic [2:0] CFG_FINAL_DELAY   = 3'd5;
    localparam logic [2:0] CFG_STABLE_TICKS  = 3'd6;
    localparam logic [2:0] CFG_SENSOR_TICKS  = 3'd7;

    // Register reset values.
    localparam logic [6:0] RST_PRE_DELAY     = 7'd20;
    localparam logic [6:0] RST_FIRST_DELAY   = 7'd20;
    localparam logic [6:0] RST_THIRD_DELAY   = 7'd50;
    localparam logic [6:0] RST_ALL_DELAY     = 7'd80;
    localparam logic [6:0] RST_RELEASE_DELAY = 7'd60;
    localparam logic [6:0] RST_FINAL_DELAY   = 7'd20;
    localparam logic [3:0] RST_STABLE_TICKS  = 4'd10;
    localparam logic [3:0] RST_SENSOR_TICKS  = 4'd10;

    // Pins that carry no sensor; they read as inactive (one).
    localparam logic [7:0] PIN_UNUSED_MASK = 8'h33;

    typedef enum logic [3:0] {
        STEP_IDLE       = 4'd0,
        STEP_LOAD       = 4'd1,
        STEP_PRE        = 4'd2,
        STEP_FIRST      = 4'd3,
        STEP_WAIT_PRESS = 4'd4,
        STEP_THIRD      = 4'd5,
        STEP_ALL        = 4'd6,
        STEP_RELEASE    = 4'd7,
        STEP_FINAL      = 4'd8,
        STEP_WAIT_END   = 4'd9
    } step_t;

    typedef logic [NUM_DELAYS-1:0][6:0] delays_t;

    typedef struct packed {
        step_t      step;
        logic [6:0] timer;
        logic [3:0] pattern;
    } chan_result_t;

    // Valve pattern shown during a step, bit v drives valve v+1.
    function automatic logic [3:0] step_pattern(step_t step);
        logic [3:0] pat;
        case (step)
            STEP_FIRST:      pat = 4'b0001;
            STEP_WAIT_PRESS: pat = 4'b0011;
            STEP_THIRD:      pat = 4'b0111;
            STEP_ALL:        pat = 4'b1111;
            STEP_RELEASE:    pat = 4'b1001;
            STEP_FINAL:      pat = 4'b1000;
            default:         pat = 4'b0000;
        endcase
        return pat;
    endfunction

    // One tick of a channel's sequence.
    function automatic chan_result_t chan_next(
        step_t      step,
        logic [6:0] timer,
        logic [1:0] mode,
        logic       press,
        logic       end_seen,
        logic [2:0] tstep,
        delays_t    delays
    );
        chan_result_t r;
        step_t        st;
        logic [6:0]   dec;
        logic         done;
        st = step;
        if (mode != MODE_ON && mode != MODE_TEST)
            st = STEP_IDLE;
        dec       = timer - 7'd1;
        done      = (dec == 7'd0);
        r.step    = st;
        r.timer   = timer;
        r.pattern = step_pattern(st);
        case (st)
            STEP_LOAD:
            begin
                r.timer = delays[CFG_PRE_DELAY];
                r.step  = STEP_PRE;
            end
            STEP_PRE:
            begin
                r.timer = dec;
                if (done)
                begin
                    r.timer = delays[CFG_FIRST_DELAY];
                    r.step  = STEP_FIRST;
                end
            end
            STEP_FIRST:
            begin
                r.timer = dec;
                if (done)
                    r.step = STEP_WAIT_PRESS;
            end
            STEP_WAIT_PRESS:
            begin
                if (press)
                begin
                    r.timer = delays[CFG_THIRD_DELAY];
                    r.step  = STEP_THIRD;
                end
            end
            STEP_THIRD:
            begin
                r.timer = dec;
                if (done)
                begin
                    r.timer = delays[CFG_ALL_DELAY];
                    r.step  = STEP_ALL;
                end
            end
            STEP_ALL:
            begin
                r.timer = dec;
                if (done)
                begin
                    r.timer = delays[CFG_RELEASE_DELAY];
                    r.step  = STEP_RELEASE;
                end
            end
            STEP_RELEASE:
            begin
                r.timer = dec;
                if (done)
                begin
                    r.timer = delays[CFG_FINAL_DELAY];
                    r.step  = STEP_FINAL;
                end
            end
            STEP_FINAL:
            begin
                r.timer = dec;
                if (done)
                    r.step = STEP_WAIT_END;
            end
            STEP_WAIT_END:
            begin
                if (end_seen)
                    r.step = STEP_IDLE;
            end
            default:
            begin
                r.step = STEP_IDLE;
            end
        endcase
        if (mode == MODE_TEST)
        begin
            case (tstep)
                3'd1:    r.pattern = 4'b0001;
                3'd2:    r.pattern = 4'b0010;
                3'd3:    r.pattern = 4'b0100;
                3'd4:    r.pattern = 4'b1000;
                default: r.pattern = 4'b0000;
            endcase
        end
        return r;
    endfunction

endpackage

[rtl/dual_valve_step_sequencer.sv]
// Top level of the dual valve step sequencer: debounce, sensor integrators and two valve sequences.
// An item passes from the input register through the update pass into the result register.
// Throughput: one item per cycle when not stalled; the update is one short pass between registers.
// A stalled result holds in the result register while the input register keeps one item waiting.
// Reset (rst_n low, asynchronous) empties both registers, clears all sensor and sequence state,
// sets the accepted pin word to all ones and loads the default delay and tick registers.
module dual_valve_step_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    // Input channel.
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    input  logic [7:0] pins,
    input  logic [6:0] command,
    input  logic [1:0] mode_a,
    input  logic [1:0] mode_b,
    input  logic [2:0] test_step,
    // Result channel.
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] drive,
    output logic [3:0] sensor_flags,
    output logic       running_a,
    output logic       running_b,
    // Configuration write port.
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [6:0] cfg_data
);
    import dvss_pkg::*;

    // Configuration registers.
    delays_t    delays_reg;
    logic [3:0] stable_ticks_reg;
    logic [3:0] sensor_ticks_reg;

    // Input register.
    logic       s1_valid_reg;
    logic       s1_req_reg;
    logic [7:0] s1_pins_reg;
    logic [6:0] s1_cmd_reg;
    logic [1:0] s1_mode_a_reg;
    logic [1:0] s1_mode_b_reg;
    logic [2:0] s1_tstep_reg;

    // Block state.
    logic [7:0] last_sample_reg,  last_sample_next;
    logic [3:0] stable_count_reg, stable_count_next;
    logic [7:0] accepted_reg,     accepted_next;
    logic [3:0] level_reg [NUM_SENSORS];
    logic [3:0] level_next [NUM_SENSORS];
    logic [3:0] flag_reg,         flag_next;
    step_t      step_a_reg,       step_a_next;
    step_t      step_b_reg,       step_b_next;
    logic [6:0] timer_a_reg,      timer_a_next;
    logic [6:0] timer_b_reg,      timer_b_next;
    logic [7:0] held_drive_reg,   held_drive_next;

    // Result register.
    logic       out_valid_reg;
    logic [7:0] drive_reg;
    logic [3:0] flags_reg;
    logic       running_a_reg;
    logic       running_b_reg;

    logic         advance;
    logic [7:0]   smp;
    logic [3:0]   sensor_active;
    chan_result_t res_a;
    chan_result_t res_b;

    // The input register hands its item on whenever the result register is free or
    // is being emptied in the same cycle, so a new transfer can land every cycle.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delays_reg[CFG_PRE_DELAY]     <= RST_PRE_DELAY;
            delays_reg[CFG_FIRST_DELAY]   <= RST_FIRST_DELAY;
            delays_reg[CFG_THIRD_DELAY]   <= RST_THIRD_DELAY;
            delays_reg[CFG_ALL_DELAY]     <= RST_ALL_DELAY;
            delays_reg[CFG_RELEASE_DELAY] <= RST_RELEASE_DELAY;
            delays_reg[CFG_FINAL_DELAY]   <= RST_FINAL_DELAY;
            stable_ticks_reg              <= RST_STABLE_TICKS;
            sensor_ticks_reg              <= RST_SENSOR_TICKS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PRE_DELAY:     delays_reg[CFG_PRE_DELAY]     <= cfg_data;
                CFG_FIRST_DELAY:   delays_reg[CFG_FIRST_DELAY]   <= cfg_data;
                CFG_THIRD_DELAY:   delays_reg[CFG_THIRD_DELAY]   <= cfg_data;
                CFG_ALL_DELAY:     delays_reg[CFG_ALL_DELAY]     <= cfg_data;
                CFG_RELEASE_DELAY: delays_reg[CFG_RELEASE_DELAY] <= cfg_data;
                CFG_FINAL_DELAY:   delays_reg[CFG_FINAL_DELAY]   <= cfg_data;
                CFG_STABLE_TICKS:  stable_ticks_reg              <= cfg_data[3:0];
                CFG_SENSOR_TICKS:  sensor_ticks_reg              <= cfg_data[3:0];
                default:           ;
            endcase
        end
    end

    // Input register: takes a transfer and holds it until the update pass uses it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_req_reg    <= req_type;
            s1_pins_reg   <= pins;
            s1_cmd_reg    <= command;
            s1_mode_a_reg <= mode_a;
            s1_mode_b_reg <= mode_b;
            s1_tstep_reg  <= test_step;
        end
    end

    // Update pass. A tick runs the debounce, then the integrators on the newly
    // accepted word, then both sequences on the new sensor flags. A command only
    // moves the step of channels in on mode and leaves the drive latch alone.
    always_comb
    begin
        last_sample_next  = last_sample_reg;
        stable_count_next = stable_count_reg;
        accepted_next     = accepted_reg;
        flag_next         = flag_reg;
        step_a_next       = step_a_reg;
        step_b_next       = step_b_reg;
        timer_a_next      = timer_a_reg;
        timer_b_next      = timer_b_reg;
        held_drive_next   = held_drive_reg;
        for (int i = 0; i < NUM_SENSORS; i++)
            level_next[i] = level_reg[i];

        // Unused pins are forced to the inactive level.
        smp = s1_pins_reg | PIN_UNUSED_MASK;

        if (s1_req_reg == REQ_TICK)
        begin
            // The word is accepted on the tick at which the count of equal
            // samples reaches the stable threshold; a change restarts the count.
            if (smp == last_sample_reg)
            begin
                if (stable_count_reg < stable_ticks_reg)
                begin
                    stable_count_next = stable_count_reg + 4'd1;
                    if (stable_count_reg + 4'd1 >= stable_ticks_reg)
                        accepted_next = last_sample_reg;
                end
            end
            else
            begin
                stable_count_next = 4'd0;
            end
            last_sample_next = smp;
        end

        // Sensors are active low: pressure A, end A, pressure B, end B.
        sensor_active = ~{accepted_next[7], accepted_next[6],
                          accepted_next[3], accepted_next[2]};

        if (s1_req_reg == REQ_TICK)
        begin
            // Each integrator sets its flag on reaching the threshold and clears
            // it only on falling back to zero, which gives hysteresis.
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                if (sensor_active[i])
                begin
                    if (level_reg[i] < sensor_ticks_reg)
                    begin
                        level_next[i] = level_reg[i] + 4'd1;
                        if (level_reg[i] + 4'd1 == sensor_ticks_reg)
                            flag_next[i] = 1'b1;
                    end
                end
                else if (level_reg[i] != 4'd0)
                begin
                    level_next[i] = level_reg[i] - 4'd1;
                    if (level_reg[i] == 4'd1)
                        flag_next[i] = 1'b0;
                end
            end
        end

        res_a = chan_next(step_a_reg, timer_a_reg, s1_mode_a_reg, flag_next[0], flag_next[1],
                          s1_tstep_reg, delays_reg);
        res_b = chan_next(step_b_reg, timer_b_reg, s1_mode_b_reg, flag_next[2], flag_next[3],
                          s1_tstep_reg, delays_reg);

        if (s1_req_reg == REQ_TICK)
        begin
            step_a_next  = res_a.step;
            timer_a_next = res_a.timer;
            step_b_next  = res_b.step;
            timer_b_next = res_b.timer;
            // Channel A valves 1..4 sit on bits 6,7,5,4 and channel B on bits 3,2,1,0.
            held_drive_next = {res_a.pattern[1], res_a.pattern[0],
                               res_a.pattern[2], res_a.pattern[3],
                               res_b.pattern[0], res_b.pattern[1],
                               res_b.pattern[2], res_b.pattern[3]};
        end
        else
        begin
            if (s1_mode_a_reg == MODE_ON)
            begin
                if (s1_cmd_reg == CMD_START)
                    step_a_next = STEP_LOAD;
                else if (s1_cmd_reg == CMD_STOP)
                    step_a_next = STEP_IDLE;
            end
            if (s1_mode_b_reg == MODE_ON)
            begin
                if (s1_cmd_reg == CMD_START)
                    step_b_next = STEP_LOAD;
                else if (s1_cmd_reg == CMD_STOP)
                    step_b_next = STEP_IDLE;
            end
        end
    end

    // State registers change only when an item passes through the update pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg  <= 8'h00;
            stable_count_reg <= 4'd0;
            accepted_reg     <= 8'hFF;
            flag_reg         <= 4'd0;
            step_a_reg       <= STEP_IDLE;
            step_b_reg       <= STEP_IDLE;
            timer_a_reg      <= 7'd0;
            timer_b_reg      <= 7'd0;
            held_drive_reg   <= 8'h00;
            for (int i = 0; i < NUM_SENSORS; i++)
                level_reg[i] <= 4'd0;
        end
        else if (advance)
        begin
            last_sample_reg  <= last_sample_next;
            stable_count_reg <= stable_count_next;
            accepted_reg     <= accepted_next;
            flag_reg         <= flag_next;
            step_a_reg       <= step_a_next;
            step_b_reg       <= step_b_next;
            timer_a_reg      <= timer_a_next;
            timer_b_reg      <= timer_b_next;
            held_drive_reg   <= held_drive_next;
            for (int i = 0; i < NUM_SENSORS; i++)
                level_reg[i] <= level_next[i];
        end
    end

    // Result register: filled by the update pass, emptied by a result transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_reg     <= held_drive_next;
            flags_reg     <= flag_next;
            running_a_reg <= (step_a_next != STEP_IDLE);
            running_b_reg <= (step_b_next != STEP_IDLE);
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive        = drive_reg;
    assign sensor_flags = flags_reg;
    assign running_a    = running_a_reg;
    assign running_b    = running_b_reg;

    // An empty result register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input not ready while result register is empty");

    // Only a tick may change the drive latch.
    a_drive_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && s1_req_reg == REQ_TICK) |=> $stable(held_drive_reg))
        else $error("drive latch changed without a tick");

    // A tick with channel A in off mode leaves it idle.
    a_off_forces_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_req_reg == REQ_TICK && s1_mode_a_reg == MODE_OFF)
        |=> step_a_reg == STEP_IDLE)
        else $error("channel A not idle after tick in off mode");

    // A set sensor flag always has a nonzero integrator level behind it.
    a_flag_has_level: assert property (@(posedge clk) disable iff (!rst_n)
        !((flag_reg[0] && level_reg[0] == 4'd0) || (flag_reg[1] && level_reg[1] == 4'd0) ||
          (flag_reg[2] && level_reg[2] == 4'd0) || (flag_reg[3] && level_reg[3] == 4'd0)))
        else $error("sensor flag set with integrator at zero");

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the dual valve step sequencer: directed cases, then random traffic.
module tb_top;
    import dvss_pkg::*;

    // The run is cut off after this much time even if results are still missing.
    localparam int TIMEOUT = 2_000_000;
    // Cycles waited after every owed status word has come back, as a margin.
    localparam int SETTLE_CYCLES = 4;
    localparam int NUM_REGS = 8;

    // Mode code that the block has no name for; it behaves like off.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    // A command code that is neither start nor stop, so the block ignores it.
    localparam logic [6:0] CMD_IGNORED = 7'h7F;

    // One request as offered on the input channel.
    typedef struct packed {
        logic       kind;
        logic [7:0] pins;
        logic [6:0] code;
        logic [1:0] ma;
        logic [1:0] mb;
        logic [2:0] lamp;
    } request_t;

    // The status word that the block returns for every request.
    typedef struct packed {
        logic [7:0] valves;
        logic [3:0] flags;
        logic       run_a;
        logic       run_b;
    } status_t;

    // One full set of register values, indexed by register number.
    typedef logic [NUM_REGS-1:0][6:0] cfg_set_t;

    // Every input starts at a known value so that nothing floats before reset ends.
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic       req_type  = REQ_TICK;
    logic [7:0] pins      = 8'hFF;
    logic [6:0] command   = 7'd0;
    logic [1:0] mode_a    = MODE_OFF;
    logic [1:0] mode_b    = MODE_OFF;
    logic [2:0] test_step = 3'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] drive;
    logic [3:0] sensor_flags;
    logic       running_a;
    logic       running_b;
    logic       cfg_we    = 1'b0;
    logic [2:0] cfg_index = CFG_PRE_DELAY;
    logic [6:0] cfg_data  = 7'd0;

    dual_valve_step_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .pins         (pins),
        .command      (command),
        .mode_a       (mode_a),
        .mode_b       (mode_b),
        .test_step    (test_step),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive        (drive),
        .sensor_flags (sensor_flags),
        .running_a    (running_a),
        .running_b    (running_b),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Mirror of the block's state, advanced once for every accepted request.
    cfg_set_t   cfg_mirror;
    logic [7:0] prev_sample = 8'h00;
    logic [3:0] match_count = 4'd0;
    logic [7:0] held_word   = 8'hFF;
    logic [3:0] integ_level [4];
    logic [3:0] sensor_seen = 4'd0;
    step_t      chan_step [2];
    logic [6:0] chan_timer [2];
    logic [7:0] valve_latch = 8'h00;

    // Status words still owed by the block, oldest first.
    status_t expected_status [$];

    // Knobs that the tests turn to shape traffic on both channels.
    bit         sender_idles    = 1'b1;
    bit         receiver_idles  = 1'b1;
    int         holdoff_request = 0;
    int         holdoff_left    = 0;
    int         stall_left      = 0;
    int         churn           = 8;
    int         mode_noise      = 0;
    bit         allow_stop      = 1'b1;
    logic [1:0] phase_ma        = MODE_ON;
    logic [1:0] phase_mb        = MODE_ON;
    logic [7:0] plant_word      = 8'hFF;

    int requests_sent   = 0;
    int results_seen    = 0;
    int mismatch_count  = 0;
    int settings_loaded = 0;
    int starts_seen     = 0;
    int cycles_finished = 0;

    initial
    begin : clock_gen
        forever
            #2 clk = ~clk;
    end

    // Builds a register set from values given in register order.
    function automatic cfg_set_t settings(
        input logic [6:0] pre_d,
        input logic [6:0] first_d,
        input logic [6:0] third_d,
        input logic [6:0] all_d,
        input logic [6:0] rel_d,
        input logic [6:0] fin_d,
        input logic [3:0] stable,
        input logic [3:0] sens
    );
        cfg_set_t s;
        s                    = '0;
        s[CFG_PRE_DELAY]     = pre_d;
        s[CFG_FIRST_DELAY]   = first_d;
        s[CFG_THIRD_DELAY]   = third_d;
        s[CFG_ALL_DELAY]     = all_d;
        s[CFG_RELEASE_DELAY] = rel_d;
        s[CFG_FINAL_DELAY]   = fin_d;
        s[CFG_STABLE_TICKS]  = {3'b000, stable};
        s[CFG_SENSOR_TICKS]  = {3'b000, sens};
        return s;
    endfunction

    // Short delays and quick sensors, so that random traffic runs whole valve cycles often.
    function automatic cfg_set_t small_settings();
        return settings(7'($urandom_range(1, 4)), 7'($urandom_range(1, 4)),
                        7'($urandom_range(1, 4)), 7'($urandom_range(1, 4)),
                        7'($urandom_range(1, 4)), 7'($urandom_range(1, 4)),
                        4'($urandom_range(1, 3)), 4'($urandom_range(1, 3)));
    endfunction

    // Valves that a step opens, bit v standing for valve v+1.
    function automatic logic [3:0] valve_pattern(step_t st);
        case (st)
            STEP_FIRST:      return 4'b0001;
            STEP_WAIT_PRESS: return 4'b0011;
            STEP_THIRD:      return 4'b0111;
            STEP_ALL:        return 4'b1111;
            STEP_RELEASE:    return 4'b1001;
            STEP_FINAL:      return 4'b1000;
            default:         return 4'b0000;
        endcase
    endfunction

    // The step timer is seven bits wide, so a timer loaded with zero wraps and lasts 128 ticks.
    function automatic logic count_down(int ch);
        chan_timer[ch] = chan_timer[ch] - 7'd1;
        return chan_timer[ch] == 7'd0;
    endfunction

    // Moves one channel by one tick and returns its share of the valve word.
    function automatic logic [7:0] advance_channel(int ch, logic [1:0] mode, logic [2:0] lamp);
        step_t      st;
        logic [3:0] pat;
        logic       press;
        logic       at_end;
        st     = chan_step[ch];
        press  = sensor_seen[2 * ch];
        at_end = sensor_seen[2 * ch + 1];
        // Off and the spare mode code both hold the channel idle.
        if (mode != MODE_ON && mode != MODE_TEST)
            st = STEP_IDLE;
        // The outputs show the step the channel was in when the tick arrived.
        pat = valve_pattern(st);
        case (st)
            STEP_LOAD:
            begin
                chan_timer[ch] = cfg_mirror[CFG_PRE_DELAY];
                st             = STEP_PRE;
            end
            STEP_PRE:
            begin
                if (count_down(ch))
                begin
                    chan_timer[ch] = cfg_mirror[CFG_FIRST_DELAY];
                    st             = STEP_FIRST;
                end
            end
            STEP_FIRST:
            begin
                if (count_down(ch))
                    st = STEP_WAIT_PRESS;
            end
            STEP_WAIT_PRESS:
            begin
                if (press)
                begin
                    chan_timer[ch] = cfg_mirror[CFG_THIRD_DELAY];
                    st             = STEP_THIRD;
                end
            end
            STEP_THIRD:
            begin
                if (count_down(ch))
                begin
                    chan_timer[ch] = cfg_mirror[CFG_ALL_DELAY];
                    st             = STEP_ALL;
                end
            end
            STEP_ALL:
            begin
                if (count_down(ch))
                begin
                    chan_timer[ch] = cfg_mirror[CFG_RELEASE_DELAY];
                    st             = STEP_RELEASE;
                end
            end
            STEP_RELEASE:
            begin
                if (count_down(ch))
                begin
                    chan_timer[ch] = cfg_mirror[CFG_FINAL_DELAY];
                    st             = STEP_FINAL;
                end
            end
            STEP_FINAL:
            begin
                if (count_down(ch))
                    st = STEP_WAIT_END;
            end
            STEP_WAIT_END:
            begin
                if (at_end)
                begin
                    st = STEP_IDLE;
                    cycles_finished++;
                end
            end
            default:
            begin
                st = STEP_IDLE;
            end
        endcase
        chan_step[ch] = st;
        // In test mode the sequence keeps going, but only the chosen lamp is lit.
        if (mode == MODE_TEST)
            pat = (lamp >= 3'd1 && lamp <= 3'd4) ? 4'b0001 << (lamp - 3'd1) : 4'b0000;
        // Channel A valves 1..4 sit on bits 6,7,5,4 and channel B valves on bits 3,2,1,0.
        if (ch == 0)
            return {pat[1], pat[0], pat[2], pat[3], 4'b0000};
        return {4'b0000, pat[0], pat[1], pat[2], pat[3]};
    endfunction

    // Applies one request to the mirror and returns the status word it should produce.
    function automatic status_t predict_status(request_t r);
        logic [7:0] smp;
        logic [3:0] stable;
        logic [3:0] sens;
        logic [2:0] pin;
        if (r.kind == REQ_TICK)
        begin
            // Pins that carry no sensor always read as inactive.
            smp    = r.pins | PIN_UNUSED_MASK;
            stable = cfg_mirror[CFG_STABLE_TICKS][3:0];
            sens   = cfg_mirror[CFG_SENSOR_TICKS][3:0];
            if (smp == prev_sample)
            begin
                if (match_count < stable)
                begin
                    match_count = match_count + 4'd1;
                    if (match_count >= stable)
                        held_word = prev_sample;
                end
            end
            else
                match_count = 4'd0;
            prev_sample = smp;
            for (int i = 0; i < 4; i++)
            begin
                // Sensors 0..3 read pins 2, 3, 6 and 7.
                pin = {i[1], 1'b1, i[0]};
                if (!held_word[pin])
                begin
                    if (integ_level[i] < sens)
                    begin
                        integ_level[i] = integ_level[i] + 4'd1;
                        if (integ_level[i] == sens)
                            sensor_seen[i] = 1'b1;
                    end
                end
                else if (integ_level[i] != 4'd0)
                begin
                    integ_level[i] = integ_level[i] - 4'd1;
                    if (integ_level[i] == 4'd0)
                        sensor_seen[i] = 1'b0;
                end
            end
            valve_latch = advance_channel(0, r.ma, r.lamp) | advance_channel(1, r.mb, r.lamp);
        end
        else
        begin
            // Commands only move channels in on mode and leave the valve latch alone.
            for (int ch = 0; ch < 2; ch++)
            begin
                if ((ch == 0 ? r.ma : r.mb) == MODE_ON)
                begin
                    if (r.code == CMD_START)
                    begin
                        chan_step[ch] = STEP_LOAD;
                        starts_seen++;
                    end
                    else if (r.code == CMD_STOP)
                        chan_step[ch] = STEP_IDLE;
                end
            end
        end
        return {valve_latch, sensor_seen, chan_step[0] != STEP_IDLE, chan_step[1] != STEP_IDLE};
    endfunction

    function automatic request_t tick_req(logic [7:0] p, logic [1:0] ma, logic [1:0] mb,
                                          logic [2:0] lamp);
        return {REQ_TICK, p, 7'd0, ma, mb, lamp};
    endfunction

    function automatic request_t command_req(logic [6:0] code, logic [1:0] ma, logic [1:0] mb);
        return {REQ_COMMAND, 8'hFF, code, ma, mb, 3'd0};
    endfunction

    // Random request shaped like plant traffic: sensor pins that settle for a while,
    // starts whenever a channel in on mode is idle, and some noise on top.
    function automatic request_t draw_request();
        request_t   r;
        logic [7:0] noise;
        logic       want_start;
        int         pick;
        if ($urandom_range(1, churn) == 1)
            plant_word = 8'($urandom_range(0, 255));
        noise  = 8'($urandom_range(0, 255));
        r.kind = REQ_TICK;
        r.pins = (plant_word & ~PIN_UNUSED_MASK) | (noise & PIN_UNUSED_MASK);
        r.code = 7'($urandom_range(0, 127));
        r.ma   = phase_ma;
        r.mb   = phase_mb;
        if (mode_noise != 0 && $urandom_range(1, mode_noise) == 1)
            r.ma = 2'($urandom_range(0, 3));
        if (mode_noise != 0 && $urandom_range(1, mode_noise) == 1)
            r.mb = 2'($urandom_range(0, 3));
        r.lamp = 3'($urandom_range(0, 7));
        want_start = (r.ma == MODE_ON && chan_step[0] == STEP_IDLE) ||
                     (r.mb == MODE_ON && chan_step[1] == STEP_IDLE);
        pick = $urandom_range(0, 99);
        if (want_start && pick < 30)
        begin
            r.kind = REQ_COMMAND;
            r.code = CMD_START;
        end
        else if (pick < 6)
        begin
            // Mostly an unknown code; now and then a stop or a start while running.
            r.kind = REQ_COMMAND;
            if (pick == 0 && allow_stop)
                r.code = CMD_STOP;
            else if (pick == 1)
                r.code = CMD_START;
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Offers one request, after a random gap if the sender idles, and holds it until the transfer happens.
    // Valid stays high after the transfer; whoever stops sending lowers it.
    task automatic issue_request(request_t r);
        int gap;
        gap = sender_idles ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= r.kind;
        pins      <= r.pins;
        command   <= r.code;
        mode_a    <= r.ma;
        mode_b    <= r.mb;
        test_step <= r.lamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_status.push_back(predict_status(r));
        requests_sent++;
    endtask

    // Stops sending and waits until every owed status word has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all registers, one per cycle; only called while the block is idle.
    task automatic load_settings(cfg_set_t s);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= s[i];
            @(posedge clk);
        end
        cfg_we     <= 1'b0;
        cfg_mirror = s;
        settings_loaded++;
    endtask

    task automatic run_random(int count);
        for (int n = 0; n < count; n++)
            issue_request(draw_request());
    endtask

    // Reset state, channels off or spare: nothing runs, nothing opens, unknown codes do nothing.
    task automatic test_idle_outputs();
        issue_request(tick_req(8'hFF, MODE_OFF, MODE_OFF, 3'd0));
        issue_request(command_req(CMD_IGNORED, MODE_ON, MODE_ON));
        issue_request(tick_req(8'h00, MODE_SPARE, MODE_SPARE, 3'd7));
    endtask

    // Every lamp index in test mode, with channel B switching between test and the spare code.
    task automatic test_lamp_patterns();
        for (int lamp = 0; lamp < 8; lamp++)
            issue_request(tick_req(8'($urandom_range(0, 255)), MODE_TEST,
                                   lamp[0] ? MODE_TEST : MODE_SPARE, lamp[2:0]));
    endtask

    // One complete valve cycle on channel A with every delay at one tick.
    // Channel B starts too but never sees its pressure sensor, so the stop ends it.
    task automatic test_short_cycle();
        drain_results();
        load_settings(settings(7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 4'd1, 4'd1));
        issue_request(command_req(CMD_START, MODE_ON, MODE_ON));
        // Pressure A active (pin 2 low).
        repeat (8) issue_request(tick_req(8'hFB, MODE_ON, MODE_ON, 3'd0));
        // Pressure A, end A and end B active.
        repeat (4) issue_request(tick_req(8'h73, MODE_ON, MODE_ON, 3'd0));
        issue_request(command_req(CMD_STOP, MODE_ON, MODE_ON));
    endtask

    // Random traffic with short delays, including a stretch with no idling on either side.
    task automatic test_random_short_delays();
        drain_results();
        load_settings(small_settings());
        phase_ma   = MODE_ON;
        phase_mb   = MODE_ON;
        churn      = 8;
        mode_noise = 40;
        allow_stop = 1'b1;
        run_random(15);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        run_random(10);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        run_random(15);
    endtask

    // The sender pauses in the middle until every status word has come back.
    task automatic test_sender_pause();
        drain_results();
        load_settings(small_settings());
        phase_mb = MODE_TEST;
        run_random(20);
        drain_results();
        phase_mb = MODE_ON;
        run_random(20);
    endtask

    // A zero delay that wraps to 128 ticks, the longest delay, and the slowest sensors.
    // Sensor pins change rarely here so that both waits can still be passed.
    task automatic test_extreme_delays();
        drain_results();
        load_settings(settings(7'd0, 7'd1, 7'd1, 7'd1, 7'd1, 7'd127, 4'd15, 4'd15));
        churn      = 40;
        mode_noise = 0;
        allow_stop = 1'b0;
        run_random(300);
    endtask

    // With both tick counts at zero the pin word is never taken and no sensor ever rises.
    task automatic test_no_debounce();
        drain_results();
        load_settings(settings(7'($urandom_range(1, 127)), 7'($urandom_range(1, 127)),
                               7'($urandom_range(1, 127)), 7'($urandom_range(1, 127)),
                               7'($urandom_range(1, 127)), 7'($urandom_range(1, 127)),
                               4'd0, 4'd0));
        churn      = 4;
        mode_noise = 10;
        allow_stop = 1'b1;
        run_random(30);
    endtask

    // The receiver holds off for a long stretch while requests keep coming back to back,
    // so the block fills up and has to drop in_ready.
    task automatic test_backpressure();
        drain_results();
        load_settings(small_settings());
        churn           = 8;
        mode_noise      = 40;
        sender_idles    = 1'b0;
        holdoff_request = 40;
        run_random(24);
        sender_idles = 1'b1;
        run_random(36);
    endtask

    // Drives out_ready and checks each status word against the oldest one owed.
    // A stall is drawn after every transfer; a requested hold-off overrides it.
    always @(posedge clk)
    begin : result_check
        status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_status.size() == 0)
            begin
                $error("status word with none owed: drive %0h flags %0h", drive, sensor_flags);
                mismatch_count++;
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("drive", want.valves, drive);
                check_field("sensor_flags", {4'd0, want.flags}, {4'd0, sensor_flags});
                check_field("running_a", {7'd0, want.run_a}, {7'd0, running_a});
                check_field("running_b", {7'd0, want.run_b}, {7'd0, running_b});
            end
            stall_left = receiver_idles ? $urandom_range(0, 10) : 0;
        end
        if (holdoff_request != 0)
        begin
            holdoff_left    = holdoff_request;
            holdoff_request = 0;
        end
        if (holdoff_left != 0)
        begin
            holdoff_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin : main_flow
        // The mirror starts from the same reset state as the block.
        cfg_mirror = settings(RST_PRE_DELAY, RST_FIRST_DELAY, RST_THIRD_DELAY, RST_ALL_DELAY,
                              RST_RELEASE_DELAY, RST_FINAL_DELAY, RST_STABLE_TICKS,
                              RST_SENSOR_TICKS);
        for (int ch = 0; ch < 2; ch++)
        begin
            chan_step[ch]  = STEP_IDLE;
            chan_timer[ch] = 7'd0;
        end
        for (int i = 0; i < 4; i++)
            integ_level[i] = 4'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_outputs();
        test_lamp_patterns();
        test_short_cycle();
        test_random_short_delays();
        test_sender_pause();
        test_extreme_delays();
        test_no_debounce();
        test_backpressure();
        drain_results();

        $display("Run covered %0d requests and %0d status words over %0d register sets.",
                 requests_sent, results_seen, settings_loaded);
        $display("Channels were started %0d times and %0d valve cycles ran to the end.",
                 starts_seen, cycles_finished);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
rtl/dvss_pkg.sv
rtl/dual_valve_step_sequencer.sv
bench/tb_top.sv
